FILE: hdl/snhc_pkg.sv
package snhc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_THR  = 2'd1;

  localparam logic [15:0] SCORE_THR_RESET = 16'd32768;
  localparam logic [15:0] DIST_THR_RESET  = 16'd256;

  typedef struct packed {
    logic [15:0]        score;
    logic [11:0]        channel_id;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               last_hit;
  } hit_t;

  typedef struct packed {
    logic [5:0]  hit_number;
    logic [11:0] channel_out;
    logic [5:0]  cluster_seed;
    logic        is_seed;
    logic        assigned;
    logic        last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_RD_SELF,
    ST_SELF_CAP,
    ST_RD_J,
    ST_J_DATA,
    ST_MUL_X,
    ST_MUL_Y,
    ST_CMP,
    ST_DECIDE,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/snhc_ram.sv
module snhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/seed_nearest_hit_clustering.sv
// Loading: one hit is taken per cycle while busy is low; an item not marked last causes no result.
// After the last hit, busy stays high while each stored hit is resolved and emitted in order.
// A seed hit is read, captured and emitted; any other hit also scans every stored hit through the
// single RAM read port and squares dx and dy for each seed on the one shared multiplier.
// Each result appears for one cycle with result_valid; the receiver cannot stall.
// Synchronous reset clears the thresholds to their defaults and the hit count; RAM is not cleared.
module seed_nearest_hit_clustering #(
  parameter int MAX_HITS   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Hit load channel.
  input  logic                              start,
  output logic                              busy,
  input  snhc_pkg::hit_t                    hit,
  // Result channel.
  output logic                              result_valid,
  output snhc_pkg::result_t                 result,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [snhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [snhc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Derived widths. Coordinates live in COORD_BITS two's complement; their
  // difference magnitude always fits COORD_BITS bits, so each square fits
  // 2*COORD_BITS bits. The sum of two squares is saturated to at most 64 bits.
  localparam int AW      = $clog2(MAX_HITS);
  localparam int CW      = $clog2(MAX_HITS + 1);
  localparam int C       = COORD_BITS;
  localparam int MUL_W   = (C > 16) ? C : 16;
  localparam int SQ_W    = 2 * C;
  localparam int SUM_W   = 2 * C + 1;
  localparam int DIST_W  = (SUM_W > 64) ? 64 : SUM_W;
  localparam int CMP_W   = (DIST_W > 32) ? DIST_W : 32;
  localparam int ENTRY_W = 2 * C + 13;
  localparam logic [SUM_W-1:0] DIST_LIM = SUM_W'({DIST_W{1'b1}});

  snhc_pkg::state_t state, state_next;

  // Configuration registers. The user must write them only while the block is idle; the block
  // itself does not enforce it, and the port is always ready.
  logic [15:0] score_threshold;
  logic [15:0] distance_threshold;

  logic [CW-1:0] hit_count;

  // Scan registers.
  logic [AW-1:0]     i_idx;
  logic [AW-1:0]     j_idx;
  logic [C-1:0]      self_x;
  logic [C-1:0]      self_y;
  logic [11:0]       self_chan;
  logic              self_seed;
  logic [C-1:0]      dxm;
  logic [C-1:0]      dym;
  logic [SQ_W-1:0]   sqx;
  logic [SQ_W-1:0]   sqy;
  logic [31:0]       thr2;
  logic              found;
  logic [DIST_W-1:0] best;
  logic [AW-1:0]     best_j;
  logic [AW-1:0]     owner;
  logic              asg;

  // RAM interface. Entry layout: {seed, x, y, channel}.
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               rd_seed;
  logic [C-1:0]       rd_x;
  logic [C-1:0]       rd_y;
  logic [11:0]        rd_chan;

  logic [C-1:0] in_x;
  logic [C-1:0] in_y;

  // Shared squaring unit: the distance threshold once per event, then dx and dy.
  logic [MUL_W-1:0]   mul_a;
  logic [2*MUL_W-1:0] prod;

  logic              load_ok;
  logic              in_seed;
  logic              accept;
  logic              j_last;
  logic              i_last;
  logic [C:0]        diff_x;
  logic [C:0]        diff_y;
  logic [C:0]        neg_x;
  logic [C:0]        neg_y;
  logic [SUM_W-1:0]  sum_wide;
  logic [DIST_W-1:0] dist_sq;
  logic              closer;
  logic              in_radius;
  logic [5:0]        hn;
  logic [5:0]        cs;

  // Take the low COORD_BITS of each coordinate as two's complement. A field
  // narrower than COORD_BITS is sign extended.
  if (COORD_BITS <= 16) begin : g_coord_narrow
    assign in_x = hit.coord_x[COORD_BITS-1:0];
    assign in_y = hit.coord_y[COORD_BITS-1:0];
  end else begin : g_coord_wide
    assign in_x = COORD_BITS'(hit.coord_x);
    assign in_y = COORD_BITS'(hit.coord_y);
  end

  assign accept    = start && !busy;
  assign load_ok   = hit_count < CW'(MAX_HITS);
  assign in_seed   = hit.score > score_threshold;
  assign ram_we    = accept && load_ok;
  assign ram_wdata = {in_seed, in_x, in_y, hit.channel_id};
  assign {rd_seed, rd_x, rd_y, rd_chan} = ram_rdata;

  snhc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_HITS)
  ) u_hit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_count[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign prod = mul_a * mul_a;

  assign j_last = (CW'(j_idx) + CW'(1)) == hit_count;
  assign i_last = (CW'(i_idx) + CW'(1)) == hit_count;

  // Absolute coordinate differences between the hit under test and seed j.
  always_comb begin
    diff_x = {self_x[C-1], self_x} - {rd_x[C-1], rd_x};
    diff_y = {self_y[C-1], self_y} - {rd_y[C-1], rd_y};
    neg_x  = -diff_x;
    neg_y  = -diff_y;
  end

  // Saturated squared distance, the running-minimum compare and the radius check. A strict
  // less-than keeps the lower seed index on a tie.
  always_comb begin
    sum_wide  = SUM_W'(sqx) + SUM_W'(sqy);
    dist_sq   = (sum_wide > DIST_LIM) ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];
    closer    = !found || (dist_sq < best);
    in_radius = found && (CMP_W'(best) < CMP_W'(thr2));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      snhc_pkg::ST_IDLE: begin
        if (accept && hit.last_hit) begin
          state_next = snhc_pkg::ST_THR;
        end
      end
      snhc_pkg::ST_THR:      state_next = snhc_pkg::ST_RD_SELF;
      snhc_pkg::ST_RD_SELF:  state_next = snhc_pkg::ST_SELF_CAP;
      snhc_pkg::ST_SELF_CAP: begin
        state_next = rd_seed ? snhc_pkg::ST_EMIT : snhc_pkg::ST_RD_J;
      end
      snhc_pkg::ST_RD_J:     state_next = snhc_pkg::ST_J_DATA;
      snhc_pkg::ST_J_DATA: begin
        if (rd_seed) begin
          state_next = snhc_pkg::ST_MUL_X;
        end else if (j_last) begin
          state_next = snhc_pkg::ST_DECIDE;
        end else begin
          state_next = snhc_pkg::ST_RD_J;
        end
      end
      snhc_pkg::ST_MUL_X:    state_next = snhc_pkg::ST_MUL_Y;
      snhc_pkg::ST_MUL_Y:    state_next = snhc_pkg::ST_CMP;
      snhc_pkg::ST_CMP: begin
        state_next = j_last ? snhc_pkg::ST_DECIDE : snhc_pkg::ST_RD_J;
      end
      snhc_pkg::ST_DECIDE:   state_next = snhc_pkg::ST_EMIT;
      snhc_pkg::ST_EMIT: begin
        state_next = i_last ? snhc_pkg::ST_IDLE : snhc_pkg::ST_RD_SELF;
      end
      default:               state_next = snhc_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath steering.
  always_comb begin
    busy         = state != snhc_pkg::ST_IDLE;
    result_valid = state == snhc_pkg::ST_EMIT;
    cfg_ready    = 1'b1;
    ram_raddr    = j_idx;
    mul_a        = MUL_W'(dym);
    hn           = '0;
    cs           = '0;
    case (state)
      snhc_pkg::ST_RD_SELF: ram_raddr = i_idx;
      snhc_pkg::ST_THR:     mul_a     = MUL_W'(distance_threshold);
      snhc_pkg::ST_MUL_X:   mul_a     = MUL_W'(dxm);
      default: begin
      end
    endcase
    hn[AW-1:0] = i_idx;
    cs[AW-1:0] = owner;
    result.hit_number   = hn;
    result.channel_out  = self_chan;
    result.cluster_seed = cs;
    result.is_seed      = self_seed;
    result.assigned     = asg;
    result.last_result  = i_last;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= snhc_pkg::ST_IDLE;
      hit_count          <= '0;
      score_threshold    <= snhc_pkg::SCORE_THR_RESET;
      distance_threshold <= snhc_pkg::DIST_THR_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          snhc_pkg::REG_SCORE_THR: score_threshold    <= cfg_data;
          snhc_pkg::REG_DIST_THR:  distance_threshold <= cfg_data;
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        hit_count <= hit_count + CW'(1);
      end else if (state == snhc_pkg::ST_EMIT && i_last) begin
        hit_count <= '0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      snhc_pkg::ST_THR: begin
        thr2  <= prod[31:0];
        i_idx <= '0;
      end
      snhc_pkg::ST_SELF_CAP: begin
        self_x    <= rd_x;
        self_y    <= rd_y;
        self_chan <= rd_chan;
        self_seed <= rd_seed;
        found     <= 1'b0;
        j_idx     <= '0;
        owner     <= i_idx;
        asg       <= rd_seed;
      end
      snhc_pkg::ST_J_DATA: begin
        dxm <= diff_x[C] ? neg_x[C-1:0] : diff_x[C-1:0];
        dym <= diff_y[C] ? neg_y[C-1:0] : diff_y[C-1:0];
        if (!rd_seed && !j_last) begin
          j_idx <= j_idx + AW'(1);
        end
      end
      snhc_pkg::ST_MUL_X: sqx <= prod[SQ_W-1:0];
      snhc_pkg::ST_MUL_Y: sqy <= prod[SQ_W-1:0];
      snhc_pkg::ST_CMP: begin
        if (closer) begin
          found  <= 1'b1;
          best   <= dist_sq;
          best_j <= j_idx;
        end
        if (!j_last) begin
          j_idx <= j_idx + AW'(1);
        end
      end
      snhc_pkg::ST_DECIDE: begin
        asg   <= in_radius;
        owner <= in_radius ? best_j : '0;
      end
      snhc_pkg::ST_EMIT: begin
        if (!i_last) begin
          i_idx <= i_idx + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // A result is only produced while the block is busy resolving an event.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while idle");

  // The final result of an event returns the block to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_result) |=> !busy)
    else $error("still busy after the final result");

  // A seed always owns itself and counts as assigned.
  a_seed_owns: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.is_seed) |->
      (result.assigned && result.cluster_seed == result.hit_number))
    else $error("seed result not self-owned");

  // Results are never back to back because each needs a RAM read.
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back result strobes");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

// Seed clustering testbench. Hits go in as beats on the start/busy channel, the
// thresholds are written over the config channel while the block is quiet, and
// every result beat is compared field by field with the labels that the local
// clustering model predicts for the event.
module tb;

  localparam int HIT_SLOTS = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  snhc_pkg::hit_t    hit_in = '0;
  logic        result_valid;
  snhc_pkg::result_t result_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [snhc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [snhc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  seed_nearest_hit_clustering #(
    .MAX_HITS  (HIT_SLOTS),
    .COORD_BITS(16)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .hit         (hit_in),
    .result_valid(result_valid),
    .result      (result_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block's event store and thresholds. The seed flag is
  // fixed when a hit is loaded, so it sees the score threshold of that moment;
  // the radius is only applied when the event closes.
  logic [15:0]        model_score_thr = snhc_pkg::SCORE_THR_RESET;
  logic [15:0]        model_dist_thr  = snhc_pkg::DIST_THR_RESET;
  logic signed [15:0] stored_x   [HIT_SLOTS];
  logic signed [15:0] stored_y   [HIT_SLOTS];
  logic [11:0]        stored_chan[HIT_SLOTS];
  bit                 stored_seed[HIT_SLOTS];
  int                 hits_loaded = 0;

  // Cluster labels that the block still owes us, oldest first.
  snhc_pkg::result_t pending_labels[$];
  snhc_pkg::result_t want_label;

  int errors  = 0;
  int gap_pct = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("tb: mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
  endtask

  // Store one accepted hit. When it closes the event, resolve every stored hit
  // against the seeds and queue one label per hit in load order.
  task automatic load_and_cluster(input snhc_pkg::hit_t h);
    snhc_pkg::result_t  lbl;
    longint             dx, dy;
    longint unsigned    d2, best, radius2;
    int                 best_j;
    bit                 found;
    if (hits_loaded < HIT_SLOTS) begin
      stored_x[hits_loaded]    = h.coord_x;
      stored_y[hits_loaded]    = h.coord_y;
      stored_chan[hits_loaded] = h.channel_id;
      stored_seed[hits_loaded] = h.score > model_score_thr;
      hits_loaded++;
    end
    if (!h.last_hit) return;
    radius2 = 64'(model_dist_thr) * 64'(model_dist_thr);
    for (int i = 0; i < hits_loaded; i++) begin
      lbl              = '0;
      lbl.hit_number   = 6'(i);
      lbl.channel_out  = stored_chan[i];
      lbl.is_seed      = stored_seed[i];
      lbl.last_result  = (i == hits_loaded - 1);
      if (stored_seed[i]) begin
        lbl.cluster_seed = 6'(i);
        lbl.assigned     = 1'b1;
      end else begin
        found  = 1'b0;
        best   = 0;
        best_j = 0;
        // Strict less-than while scanning upward keeps the lowest seed on a tie.
        for (int j = 0; j < hits_loaded; j++) begin
          if (!stored_seed[j]) continue;
          dx = longint'(stored_x[i]) - longint'(stored_x[j]);
          dy = longint'(stored_y[i]) - longint'(stored_y[j]);
          d2 = longint'(dx * dx + dy * dy);
          if (!found || d2 < best) begin
            found  = 1'b1;
            best   = d2;
            best_j = j;
          end
        end
        if (found && best < radius2) begin
          lbl.cluster_seed = 6'(best_j);
          lbl.assigned     = 1'b1;
        end
      end
      pending_labels = {pending_labels, lbl};
    end
    hits_loaded = 0;
  endtask

  // Sends one hit beat. The start line is left high after acceptance so that a
  // following beat can go out on the very next edge; anything that lets time
  // pass without sending drops start first.
  task automatic send_hit(input snhc_pkg::hit_t h);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start  <= 1'b0;
      hit_in <= random_hit(1'b0);
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    start  <= 1'b1;
    hit_in <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    load_and_cluster(h);
  endtask

  // Stop loading and wait until every owed label has come back, then let the block
  // settle into idle.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers are written back to back with valid held high across the
  // two beats. Only called while the block is quiet.
  task automatic set_thresholds(input logic [15:0] score_thr, input logic [15:0] dist_thr);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= snhc_pkg::REG_SCORE_THR;
    cfg_data  <= score_thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_score_thr = score_thr;
    cfg_index <= snhc_pkg::REG_DIST_THR;
    cfg_data  <= dist_thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_dist_thr = dist_thr;
    cfg_valid <= 1'b0;
  endtask

  function automatic snhc_pkg::hit_t make_hit(input int score, input int chan, input int x,
                                              input int y, input bit last);
    snhc_pkg::hit_t h;
    h.score      = 16'(score);
    h.channel_id = 12'(chan);
    h.coord_x    = 16'(x);
    h.coord_y    = 16'(y);
    h.last_hit   = last;
    return h;
  endfunction

  // Most random hits sit in a window 1536 units wide so that radii in the
  // hundreds actually capture them; the rest span the whole coordinate range.
  function automatic snhc_pkg::hit_t random_hit(input bit last);
    snhc_pkg::hit_t h;
    h.score      = 16'($urandom());
    h.channel_id = 12'($urandom());
    if ($urandom_range(0, 99) < 70) begin
      h.coord_x = 16'(int'($urandom_range(0, 1535)) - 768);
      h.coord_y = 16'(int'($urandom_range(0, 1535)) - 768);
    end else begin
      h.coord_x = 16'($urandom());
      h.coord_y = 16'($urandom());
    end
    h.last_hit = last;
    return h;
  endfunction

  // Every result beat is taken on the edge that ends its cycle; there is no
  // way to hold it off, so the check happens right there.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_labels.size() == 0) begin
        report_mismatch("unexpected result, hit_number", result_out.hit_number, -1);
      end else begin
        want_label = pending_labels.pop_front();
        if (result_out.hit_number !== want_label.hit_number)
          report_mismatch("hit_number", result_out.hit_number, want_label.hit_number);
        if (result_out.channel_out !== want_label.channel_out)
          report_mismatch("channel_out", result_out.channel_out, want_label.channel_out);
        if (result_out.cluster_seed !== want_label.cluster_seed)
          report_mismatch("cluster_seed", result_out.cluster_seed, want_label.cluster_seed);
        if (result_out.is_seed !== want_label.is_seed)
          report_mismatch("is_seed", result_out.is_seed, want_label.is_seed);
        if (result_out.assigned !== want_label.assigned)
          report_mismatch("assigned", result_out.assigned, want_label.assigned);
        if (result_out.last_result !== want_label.last_result)
          report_mismatch("last_result", result_out.last_result, want_label.last_result);
      end
    end
  end

  // Reset thresholds untouched: a score exactly at the threshold is not a
  // seed, one above is, and a hit just inside one unit of radius joins it.
  // Then a single-hit event with no seed at all.
  task automatic test_reset_defaults();
    send_hit(make_hit(32768, 1, 0, 0, 1'b0));
    send_hit(make_hit(32769, 2, 255, 0, 1'b0));
    send_hit(make_hit(40000, 3, 0, 255, 1'b1));
    send_hit(make_hit(0, 4, 100, -100, 1'b1));
  endtask

  // Extreme field values: corners of the coordinate plane, channel and score
  // limits, and the widest radius, which still misses the opposite corner.
  task automatic test_field_extremes();
    set_thresholds(16'd32768, 16'hFFFF);
    send_hit(make_hit(65535, 4095, -32768, -32768, 1'b0));
    send_hit(make_hit(0, 0, 32767, 32767, 1'b0));
    send_hit(make_hit(12345, 2730, -32668, -32768, 1'b0));
    send_hit(make_hit(65535, 1365, 32767, -32768, 1'b1));
  endtask

  // A hit exactly one radius from its seed stays out, one unit closer gets in.
  // Then a hit halfway between two seeds goes to the lower-numbered one.
  task automatic test_ties_and_radius();
    set_thresholds(16'd32768, 16'd256);
    send_hit(make_hit(100, 10, 512, 0, 1'b0));
    send_hit(make_hit(60000, 11, 256, 0, 1'b0));
    send_hit(make_hit(200, 12, 511, 0, 1'b1));
    set_thresholds(16'd32768, 16'd512);
    send_hit(make_hit(0, 20, 0, 0, 1'b0));
    send_hit(make_hit(50000, 21, -256, 0, 1'b0));
    send_hit(make_hit(50000, 22, 256, 0, 1'b0));
    send_hit(make_hit(0, 23, 0, -600, 1'b1));
  endtask

  // Top score threshold leaves no seed at all; a zero radius rejects even a
  // hit sitting exactly on its seed.
  task automatic test_no_seeds();
    set_thresholds(16'hFFFF, 16'd1000);
    send_hit(make_hit(65535, 30, 0, 0, 1'b0));
    send_hit(make_hit(65535, 31, 10, 10, 1'b1));
    set_thresholds(16'd0, 16'd0);
    send_hit(make_hit(1, 32, 77, 77, 1'b0));
    send_hit(make_hit(0, 33, 77, 77, 1'b1));
  endtask

  // Thresholds change inside an event: the first hit keeps the seed decision
  // it got at load time, while the new radius applies to the whole event.
  task automatic test_threshold_timing();
    set_thresholds(16'd32768, 16'd256);
    send_hit(make_hit(40000, 40, 0, 0, 1'b0));
    set_thresholds(16'd50000, 16'd2000);
    send_hit(make_hit(45000, 41, 1000, 0, 1'b1));
  endtask

  // An event longer than the store: the tail is dropped, and the dropped beat
  // carrying the last flag still closes the event.
  task automatic test_overflow();
    set_thresholds(16'd32768, 16'd1000);
    for (int k = 0; k < HIT_SLOTS + 3; k++)
      send_hit(make_hit((k % 8 == 0) ? 65535 : int'($urandom_range(0, 32768)),
                        int'($urandom_range(0, 4095)),
                        int'($urandom_range(0, 1535)) - 768,
                        int'($urandom_range(0, 1535)) - 768,
                        k == HIT_SLOTS + 2));
  endtask

  // Random events in three idling phases: none, sender idle about two beats in
  // three, and about one in three. Thresholds move between events now and then,
  // including their extremes.
  task automatic test_random_events();
    int sent;
    int n;
    logic [15:0] sthr;
    logic [15:0] dthr;
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 0 : (phase == 1) ? 66 : 30;
      sent = 0;
      while (sent < 42) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0:       sthr = 16'd0;
            1:       sthr = 16'hFFFF;
            default: sthr = 16'($urandom_range(0, 65535));
          endcase
          case ($urandom_range(0, 5))
            0:       dthr = 16'd0;
            1:       dthr = 16'hFFFF;
            default: dthr = 16'($urandom_range(0, 1200));
          endcase
          set_thresholds(sthr, dthr);
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          send_hit(random_hit(k == n - 1));
          sent++;
        end
      end
    end
    gap_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_ties_and_radius();
    test_no_seeds();
    test_threshold_timing();
    test_overflow();
    test_random_events();

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_labels.size() != 0)
      report_mismatch("labels never delivered", 0, pending_labels.size());
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
hdl/snhc_pkg.sv
hdl/snhc_ram.sv
hdl/seed_nearest_hit_clustering.sv
test/tb.sv
